// ===== rtl/ccs_pkg.sv =====
`default_nettype none

package ccs_pkg;

    // Characters that steer the scanner
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Step queue between front and back
    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    // Scanner mode
    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_BLOCK  = 4'b0100,
        MODE_LINE   = 4'b1000
    } t_mode;

    // Result count of one input byte
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Results caused by one input byte: up to two kept bytes and the end flag
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [1:0] cnt;
        logic       done;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== rtl/ccs_front.sv =====
`default_nettype none

module ccs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_last,
    input  wire ccs_pkg::t_q_stat i_stat,
    output logic               o_ready,
    output logic               o_push,
    output ccs_pkg::t_rec      o_rec
);
    import ccs_pkg::*;

    t_mode      r_mode, n_mode;
    logic       r_held_v, n_held_v;
    logic [7:0] r_held_c, n_held_c;
    t_rec       w_rec;
    logic       w_used;
    logic       w_acc;

    function automatic t_rec add_char(input t_rec r, input logic [7:0] c);
        t_rec o;
        o = r;
        if (r.cnt == CNT_NONE) begin
            o.c0  = c;
            o.cnt = CNT_ONE;
        end else if (r.cnt == CNT_ONE) begin
            o.c1  = c;
            o.cnt = CNT_TWO;
        end
        return o;
    endfunction

    assign o_ready = !i_stat.full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_mode   = r_mode;
        n_held_v = r_held_v;
        n_held_c = r_held_c;
        w_used   = 1'b0;
        w_rec    = '0;

        // Resolve the held byte against the new one
        if (r_held_v) begin
            n_held_v = 1'b0;
            unique case (r_mode)
                MODE_NORMAL: begin
                    if (i_char == CH_STAR) begin
                        n_mode = MODE_BLOCK;
                        w_used = 1'b1;
                    end else if (i_char == CH_SLASH) begin
                        n_mode = MODE_LINE;
                        w_used = 1'b1;
                    end else begin
                        w_rec = add_char(w_rec, r_held_c);
                    end
                end
                MODE_STRING: begin
                    w_rec = add_char(w_rec, r_held_c);
                    if (i_char == CH_QUOTE) begin
                        w_rec  = add_char(w_rec, i_char);
                        w_used = 1'b1;
                    end
                end
                MODE_BLOCK: begin
                    if (i_char == CH_SLASH) begin
                        n_mode = MODE_NORMAL;
                        w_used = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (!w_used) begin
            unique case (n_mode)
                MODE_NORMAL: begin
                    if (i_char == CH_QUOTE) begin
                        w_rec  = add_char(w_rec, i_char);
                        n_mode = MODE_STRING;
                    end else if (i_char == CH_SLASH) begin
                        n_held_v = 1'b1;
                        n_held_c = i_char;
                    end else begin
                        w_rec = add_char(w_rec, i_char);
                    end
                end
                MODE_STRING: begin
                    if (i_char == CH_QUOTE) begin
                        w_rec  = add_char(w_rec, i_char);
                        n_mode = MODE_NORMAL;
                    end else if (i_char == CH_BSLASH) begin
                        n_held_v = 1'b1;
                        n_held_c = i_char;
                    end else begin
                        w_rec = add_char(w_rec, i_char);
                    end
                end
                MODE_BLOCK: begin
                    if (i_char == CH_STAR) begin
                        n_held_v = 1'b1;
                        n_held_c = i_char;
                    end
                end
                default: begin
                    if (i_char == CH_NL) begin
                        w_rec  = add_char(w_rec, i_char);
                        n_mode = MODE_NORMAL;
                    end
                end
            endcase
        end

        // Flush at end of text: pass a held slash or backslash, drop a held star
        if (i_last) begin
            if (n_held_v && n_mode != MODE_BLOCK) begin
                w_rec = add_char(w_rec, n_held_c);
            end
            n_held_v = 1'b0;
            n_mode   = MODE_NORMAL;
        end
        w_rec.done = i_last;
    end

    assign o_push = w_acc && (w_rec.cnt != CNT_NONE || i_last);
    assign o_rec  = w_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_held_v <= 1'b0;
        end else if (w_acc) begin
            r_mode   <= n_mode;
            r_held_v <= n_held_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_held_c <= n_held_c;
        end
    end

    a_held_not_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> r_mode != MODE_LINE)
        else $error("byte held in line comment");

    a_push_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_rec.cnt != CNT_NONE || o_rec.done))
        else $error("empty step pushed");

endmodule

`default_nettype wire

// ===== rtl/ccs_queue.sv =====
`default_nettype none

module ccs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ccs_pkg::t_rec i_rec,
    input  wire logic          i_pop,
    output ccs_pkg::t_rec      o_rec,
    output ccs_pkg::t_q_stat   o_stat
);
    import ccs_pkg::*;

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rec        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/ccs_back.sv =====
`default_nettype none

module ccs_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ccs_pkg::t_rec    i_rec,
    input  wire ccs_pkg::t_q_stat i_stat,
    output logic                  o_pop,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output logic [7:0]            o_char,
    output logic                  o_has,
    output logic                  o_done
);
    import ccs_pkg::*;

    logic       r_valid;
    logic       r_idx, n_idx;
    logic [7:0] r_char, n_char;
    logic       r_has, n_has;
    logic       r_done, n_done;
    logic       w_load;

    assign w_load = (!r_valid || i_ready) && !i_stat.empty;

    // Split a two-byte step into two transfers; pop on the last one
    always_comb begin
        n_idx  = 1'b0;
        o_pop  = 1'b0;
        n_char = r_idx ? i_rec.c1 : i_rec.c0;
        n_has  = (i_rec.cnt != CNT_NONE);
        n_done = i_rec.done;
        if (!r_idx && i_rec.cnt == CNT_TWO) begin
            n_idx  = 1'b1;
            n_done = 1'b0;
        end else begin
            o_pop = w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= n_char;
            r_has  <= n_has;
            r_done <= n_done;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_has   = r_has;
    assign o_done  = r_done;

    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx |-> (!i_stat.empty && i_rec.cnt == CNT_TWO))
        else $error("second byte without a two-byte step");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_has) |-> r_done)
        else $error("empty transfer without end of text");

endmodule

`default_nettype wire

// ===== rtl/c_comment_stripper.sv =====
`default_nettype none

// Channel   Dir  tdata           tuser      tlast
// s_axis    in   char_in [7:0]   -          end_of_text
// m_axis    out  char_out [7:0]  has_char   text_done
//
// One input byte per cycle. A byte that yields two kept bytes takes two
// output transfers; the output register then drains one per ready cycle.
// Input and output are decoupled by a four-entry step queue; s_axis_tready
// drops only when that queue is full. A byte that keeps nothing and does not
// end the text takes no entry, so a stalled output holds the input once four
// steps with results wait in the queue. Synchronous active-low reset returns
// the scanner to normal mode with nothing held and empties the queue.
module c_comment_stripper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] char_out
    output logic            m_axis_tuser,   // [0] has_char
    output logic            m_axis_tlast
);
    import ccs_pkg::*;

    t_rec    w_push_rec;
    t_rec    w_head_rec;
    t_q_stat w_stat;
    logic    w_push;
    logic    w_pop;

    ccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_stat  (w_stat),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    ccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_stat  (w_stat)
    );

    ccs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (w_head_rec),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_char  (m_axis_tdata),
        .o_has   (m_axis_tuser),
        .o_done  (m_axis_tlast)
    );

endmodule

`default_nettype wire
